[rtl/core/ppd_pkg.sv]
// ---------------------------------------------------------------------------
// ppd_pkg: shared types for the priority task dispatcher
// Command codes, result codes, sequencer states and the task entry layout.
// ---------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

  localparam int unsigned IdW   = 8;
  localparam int unsigned PrioW = 3;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_RETURN  = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    FIN_NONE    = 2'd0,
    FIN_ENDED   = 2'd1,
    FIN_STACKED = 2'd2
  } finish_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_NO_TASK  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DSP_RD,
    ST_DSP,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[rtl/core/preemptive_priority_task_dispatcher_top.sv]
// ---------------------------------------------------------------------------
// preemptive_priority_task_dispatcher_top: preemptive priority dispatcher
// Pending pool, preempted-task stack and running task, driven by commands.
// ---------------------------------------------------------------------------
// Each request carries one command and produces exactly one result. The
// pending pool is a ring in a RAM kept sorted by priority (FIFO among equal
// priorities); the preempted tasks sit in a second RAM used as a stack. A
// request passes through accept, execute, dispatch read, dispatch and
// output before the block is ready again. An enqueue into a pool that is
// not full first walks the pool from its tail, with one read and one
// compare/write-back for each entry it moves past (single RAM read port);
// then it writes the new entry on the read step when it reaches the front,
// or after a read and a compare when it stops behind an entry at least as
// urgent; a full pool skips the walk. The block takes a new request only
// once the previous one has been handed to the output register, which then
// holds the result until the sink takes it; the output state waits while an
// older result still waits there. Pops advance the ring head, so no entry is
// ever shifted on dispatch. Both RAMs start undefined: only entries below the
// fill counts are ever used.
// ---------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_task_dispatcher_top #(
  parameter int unsigned POOL_DEPTH  = 16,
  parameter int unsigned STACK_DEPTH = 8,
  parameter int unsigned PRIO_LEVELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] task_id, [10:8] priority_req
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd
  // result side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] dispatched, [8:1] active_task, [11:9] current_priority, [12] busy_res,
  // [13] preempt_request, [15:14] finish_kind, [17:16] error_code
  output logic      [23:0] m_axis_tdata
);

  localparam int unsigned PoolAw  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned StackAw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned PoolCw  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned StackCw = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SumW    = PoolAw + 2;
  localparam int unsigned PrioMax = PRIO_LEVELS - 1;

  // Ring position of logical pool slot j.
  function automatic logic [PoolAw-1:0] phys(input logic [PoolAw-1:0] head,
                                             input logic [PoolCw-1:0] j);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(j);
    if (sum >= SumW'(POOL_DEPTH)) begin
      sum = sum - SumW'(POOL_DEPTH);
    end
    return sum[PoolAw-1:0];
  endfunction

  ppd_pkg::state_e state_q, state_d;

  logic [2:0]             cmd_q, cmd_d;
  ppd_pkg::entry_t        new_q, new_d;
  ppd_pkg::entry_t        run_q, run_d;
  logic                   exec_q, exec_d;
  logic                   en_q, en_d;
  logic                   pend_q, pend_d;
  logic [PoolAw-1:0]      head_q, head_d;
  logic [PoolCw-1:0]      pool_cnt_q, pool_cnt_d;
  logic [StackCw-1:0]     stk_cnt_q, stk_cnt_d;
  logic [PoolCw-1:0]      k_q, k_d;
  logic                   preq_q, preq_d;
  logic                   disp_q, disp_d;
  ppd_pkg::finish_e       fin_q, fin_d;
  ppd_pkg::err_e          err_q, err_d;
  logic                   out_valid_q, out_valid_d;
  logic [23:0]            out_data_q, out_data_d;

  logic                   pool_we, stk_we;
  logic [PoolAw-1:0]      pool_waddr, pool_raddr;
  ppd_pkg::entry_t        pool_wdata, pool_rdata, stk_rdata;
  logic [StackAw-1:0]     stk_waddr, stk_raddr;
  logic [2:0]             in_prio, sat_prio;
  logic                   accept, from_stack;

  assign s_axis_tready = (state_q == ppd_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Clamp priorities above the highest configured level.
  assign in_prio  = s_axis_tdata[10:8];
  assign sat_prio = (32'(in_prio) > PrioMax) ? 3'(PrioMax) : in_prio;

  assign from_stack = (stk_cnt_q != '0) &&
                      ((pool_cnt_q == '0) || (stk_rdata.prio >= pool_rdata.prio));

  assign stk_raddr  = StackAw'(stk_cnt_q - StackCw'(1));
  assign stk_waddr  = StackAw'(stk_cnt_q);
  assign pool_raddr = (state_q == ppd_pkg::ST_INS_RD) ?
                      phys(head_q, k_q - PoolCw'(1)) : head_q;

  ppd_ram #(.Width(ppd_pkg::EntryW), .Depth(POOL_DEPTH)) u_pool_ram (
    .clk_i  (clk_i),
    .we_i   (pool_we),
    .waddr_i(pool_waddr),
    .wdata_i(pool_wdata),
    .raddr_i(pool_raddr),
    .rdata_o(pool_rdata)
  );

  ppd_ram #(.Width(ppd_pkg::EntryW), .Depth(STACK_DEPTH)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(run_q),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppd_pkg::ST_IDLE: begin
        if (accept) state_d = ppd_pkg::ST_EXEC;
      end
      ppd_pkg::ST_EXEC: begin
        if ((cmd_q == ppd_pkg::CMD_ENQUEUE) && (pool_cnt_q != PoolCw'(POOL_DEPTH))) begin
          state_d = ppd_pkg::ST_INS_RD;
        end else begin
          state_d = ppd_pkg::ST_DSP_RD;
        end
      end
      ppd_pkg::ST_INS_RD: begin
        state_d = (k_q == '0) ? ppd_pkg::ST_DSP_RD : ppd_pkg::ST_INS_CMP;
      end
      ppd_pkg::ST_INS_CMP: begin
        state_d = (pool_rdata.prio < new_q.prio) ? ppd_pkg::ST_INS_RD : ppd_pkg::ST_DSP_RD;
      end
      ppd_pkg::ST_DSP_RD: state_d = ppd_pkg::ST_DSP;
      ppd_pkg::ST_DSP:    state_d = ppd_pkg::ST_OUT;
      ppd_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) state_d = ppd_pkg::ST_IDLE;
      end
      default: state_d = ppd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls per state.
  always_comb begin
    cmd_d      = cmd_q;
    new_d      = new_q;
    run_d      = run_q;
    exec_d     = exec_q;
    en_d       = en_q;
    pend_d     = pend_q;
    head_d     = head_q;
    pool_cnt_d = pool_cnt_q;
    stk_cnt_d  = stk_cnt_q;
    k_d        = k_q;
    preq_d     = preq_q;
    disp_d     = disp_q;
    fin_d      = fin_q;
    err_d      = err_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    pool_we    = 1'b0;
    pool_waddr = phys(head_q, k_q);
    pool_wdata = new_q;
    stk_we     = 1'b0;
    case (state_q)
      ppd_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d   = s_axis_tuser;
          new_d   = '{id: s_axis_tdata[7:0], prio: sat_prio};
          preq_d  = 1'b0;
          disp_d  = 1'b0;
          fin_d   = ppd_pkg::FIN_NONE;
          err_d   = ppd_pkg::ERR_OK;
        end
      end
      ppd_pkg::ST_EXEC: begin
        case (cmd_q)
          ppd_pkg::CMD_ENQUEUE: begin
            // raise one preempt only; the insertion is tried regardless
            if (exec_q && !pend_q && (new_q.prio > run_q.prio)) begin
              pend_d = 1'b1;
              preq_d = 1'b1;
            end
            if (pool_cnt_q == PoolCw'(POOL_DEPTH)) begin
              err_d = ppd_pkg::ERR_OVERFLOW;
            end
            k_d = pool_cnt_q;
          end
          ppd_pkg::CMD_RETURN: begin
            if (!exec_q) begin
              err_d = ppd_pkg::ERR_NO_TASK;
            end else begin
              exec_d = 1'b0;
              if (pend_q) begin
                pend_d = 1'b0;
                fin_d  = ppd_pkg::FIN_STACKED;
                if (stk_cnt_q < StackCw'(STACK_DEPTH)) begin
                  stk_we    = 1'b1;
                  stk_cnt_d = stk_cnt_q + StackCw'(1);
                end else begin
                  err_d = ppd_pkg::ERR_OVERFLOW;
                end
              end else begin
                fin_d = ppd_pkg::FIN_ENDED;
              end
            end
          end
          ppd_pkg::CMD_START: en_d = 1'b1;
          ppd_pkg::CMD_STOP: begin
            if (en_q) begin
              en_d = 1'b0;
              if (exec_q && !pend_q) begin
                pend_d = 1'b1;
                preq_d = 1'b1;
              end
            end
          end
          ppd_pkg::CMD_CLEAR: begin
            pool_cnt_d = '0;
            stk_cnt_d  = '0;
          end
          ppd_pkg::CMD_QUERY: begin
            if (!exec_q) err_d = ppd_pkg::ERR_NO_TASK;
          end
          default: ;
        endcase
      end
      ppd_pkg::ST_INS_RD: begin
        // reached the front: the new entry becomes slot zero
        if (k_q == '0) begin
          pool_we    = 1'b1;
          pool_cnt_d = pool_cnt_q + PoolCw'(1);
        end
      end
      ppd_pkg::ST_INS_CMP: begin
        pool_we = 1'b1;
        if (pool_rdata.prio < new_q.prio) begin
          // move the less urgent entry one slot back and keep walking
          pool_wdata = pool_rdata;
          k_d        = k_q - PoolCw'(1);
        end else begin
          pool_cnt_d = pool_cnt_q + PoolCw'(1);
        end
      end
      ppd_pkg::ST_DSP: begin
        if (en_q && !exec_q && ((stk_cnt_q != '0) || (pool_cnt_q != '0))) begin
          exec_d = 1'b1;
          disp_d = 1'b1;
          if (from_stack) begin
            run_d     = stk_rdata;
            stk_cnt_d = stk_cnt_q - StackCw'(1);
          end else begin
            run_d      = pool_rdata;
            head_d     = phys(head_q, PoolCw'(1));
            pool_cnt_d = pool_cnt_q - PoolCw'(1);
          end
        end
      end
      ppd_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, err_q, fin_q, preq_q, exec_q,
                         exec_q ? run_q.prio : 3'd0,
                         exec_q ? run_q.id : 8'd0, disp_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppd_pkg::ST_IDLE;
      run_q       <= '0;
      exec_q      <= 1'b0;
      en_q        <= 1'b0;
      pend_q      <= 1'b0;
      head_q      <= '0;
      pool_cnt_q  <= '0;
      stk_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      exec_q      <= exec_d;
      en_q        <= en_d;
      pend_q      <= pend_d;
      head_q      <= head_d;
      pool_cnt_q  <= pool_cnt_d;
      stk_cnt_q   <= stk_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    new_q      <= new_d;
    k_q        <= k_d;
    preq_q     <= preq_d;
    disp_q     <= disp_d;
    fin_q      <= fin_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_cnt_q <= PoolCw'(POOL_DEPTH)) else $error("pool count past depth");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cnt_q <= StackCw'(STACK_DEPTH)) else $error("stack count past depth");
  a_pend_needs_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> exec_q) else $error("preempt pending with no running task");
  a_disp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[0]) |-> out_data_q[12]) else $error("dispatch while idle");
`endif

endmodule

`default_nettype wire

[rtl/core/ppd_ram.sv]
// ---------------------------------------------------------------------------
// ppd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ppd_ram #(
  parameter int unsigned Width = 11,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb: request/result testbench for the preemptive priority task dispatcher
// Drives command requests from a queue through a bursty driver, predicts
// each result with a behavioral model of the pool, the stack and the
// running task, and checks every result field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_N    = 16;
  localparam int unsigned STACK_N   = 8;
  localparam int unsigned IDLE_MAX  = 5000;

  // Command codes with no defined action.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] id;
    logic [2:0] prio;
  } req_t;

  // Laid out like m_axis_tdata[17:0], last member in the lowest bits.
  typedef struct packed {
    ppd_pkg::err_e    err;
    ppd_pkg::finish_e fin;
    logic             preempt;
    logic             busy;
    logic [2:0]       task_prio;
    logic [7:0]       task_id;
    logic             dispatched;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  preemptive_priority_task_dispatcher_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] task_id, [10:8] priority_req
    .s_axis_tuser  (s_axis_tuser),   // [2:0] cmd
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [0] dispatched, [8:1] active_task, [11:9] current_priority,
    // [12] busy_res, [13] preempt_request, [15:14] finish_kind,
    // [17:16] error_code
    .m_axis_tdata  (m_axis_tdata)
  );

  // Scheduler shadow state
  ppd_pkg::entry_t pool_q[$];
  ppd_pkg::entry_t stack_q[$];
  ppd_pkg::entry_t run_entry;
  bit     running, enabled, yield_pending;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   n_errors = 0;

  // Pressure controls
  bit   hold_sink = 1'b0;
  bit   hold_src  = 1'b0;

  // Compute the result of one request and advance the shadow state.
  function automatic res_t dispatch_step(req_t r);
    res_t            o;
    ppd_pkg::entry_t e;
    int              pos;
    bit              take_stack;
    o = '0;
    e.id = r.id;
    e.prio = r.prio;
    case (r.cmd)
      ppd_pkg::CMD_ENQUEUE: begin
        if (running && r.prio > run_entry.prio && !yield_pending) begin
          yield_pending = 1'b1;
          o.preempt = 1'b1;
        end
        if (pool_q.size() >= POOL_N) begin
          o.err = ppd_pkg::ERR_OVERFLOW;
        end else begin
          pos = 0;
          while (pos < pool_q.size() && pool_q[pos].prio >= e.prio) pos++;
          pool_q.insert(pos, e);
        end
      end
      ppd_pkg::CMD_RETURN: begin
        if (!running) begin
          o.err = ppd_pkg::ERR_NO_TASK;
        end else begin
          running = 1'b0;
          if (yield_pending) begin
            yield_pending = 1'b0;
            o.fin = ppd_pkg::FIN_STACKED;
            if (stack_q.size() < STACK_N) stack_q.push_back(run_entry);
            else o.err = ppd_pkg::ERR_OVERFLOW;
          end else begin
            o.fin = ppd_pkg::FIN_ENDED;
          end
        end
      end
      ppd_pkg::CMD_START: enabled = 1'b1;
      ppd_pkg::CMD_STOP: begin
        if (enabled) begin
          enabled = 1'b0;
          if (running && !yield_pending) begin
            yield_pending = 1'b1;
            o.preempt = 1'b1;
          end
        end
      end
      ppd_pkg::CMD_CLEAR: begin
        pool_q.delete();
        stack_q.delete();
      end
      ppd_pkg::CMD_QUERY: if (!running) o.err = ppd_pkg::ERR_NO_TASK;
      default: ;
    endcase
    if (enabled && !running && (stack_q.size() > 0 || pool_q.size() > 0)) begin
      take_stack = stack_q.size() > 0 &&
                   (pool_q.size() == 0 || stack_q[$].prio >= pool_q[0].prio);
      if (take_stack) run_entry = stack_q.pop_back();
      else run_entry = pool_q.pop_front();
      running = 1'b1;
      o.dispatched = 1'b1;
    end
    o.busy = running;
    o.task_id = running ? run_entry.id : 8'd0;
    o.task_prio = running ? run_entry.prio : 3'd0;
    return o;
  endfunction

  function automatic req_t mk_req(logic [2:0] c, logic [7:0] id, logic [2:0] p);
    req_t r;
    r.cmd = c;
    r.id = id;
    r.prio = p;
    return r;
  endfunction

  // Weighted random command: mostly enqueues and returns to keep things moving.
  function automatic req_t rand_req();
    int unsigned w;
    logic [2:0]  c;
    w = $urandom_range(99);
    if (w < 40) c = ppd_pkg::CMD_ENQUEUE;
    else if (w < 72) c = ppd_pkg::CMD_RETURN;
    else if (w < 80) c = ppd_pkg::CMD_START;
    else if (w < 86) c = ppd_pkg::CMD_STOP;
    else if (w < 89) c = ppd_pkg::CMD_CLEAR;
    else if (w < 96) c = ppd_pkg::CMD_QUERY;
    else c = ($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
    return mk_req(c, 8'($urandom), 3'($urandom));
  endfunction

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    req_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.push_back(dispatch_step(pending_reqs.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current request
      end else if (hold_src || pending_reqs.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        r = pending_reqs[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, r.prio, r.id};
        s_axis_tuser <= r.cmd;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: stall on its own pattern, compare each result with the oldest
  // prediction.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[17:0]);
        if (expected_res.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          n_errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got.dispatched !== exp_r.dispatched) begin
            $error("dispatched: expected %0d, got %0d", exp_r.dispatched, got.dispatched);
            n_errors++;
          end
          if (got.task_id !== exp_r.task_id) begin
            $error("active_task: expected %0d, got %0d", exp_r.task_id, got.task_id);
            n_errors++;
          end
          if (got.task_prio !== exp_r.task_prio) begin
            $error("current_priority: expected %0d, got %0d", exp_r.task_prio,
                   got.task_prio);
            n_errors++;
          end
          if (got.busy !== exp_r.busy) begin
            $error("busy_res: expected %0d, got %0d", exp_r.busy, got.busy);
            n_errors++;
          end
          if (got.preempt !== exp_r.preempt) begin
            $error("preempt_request: expected %0d, got %0d", exp_r.preempt, got.preempt);
            n_errors++;
          end
          if (got.fin !== exp_r.fin) begin
            $error("finish_kind: expected %0d, got %0d", exp_r.fin, got.fin);
            n_errors++;
          end
          if (got.err !== exp_r.err) begin
            $error("error_code: expected %0d, got %0d", exp_r.err, got.err);
            n_errors++;
          end
        end
      end
      if ($urandom_range(199) == 0) stall_mode <= $urandom_range(2);
      if (hold_sink) m_axis_tready <= 1'b0;
      else case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(3) != 0);
        default: m_axis_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // Watchdog: end the run when no request or result is taken for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (!hold_sink)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command, each special case.
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_RETURN, 8'd0, 3'd0));   // return, no task
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_QUERY, 8'd0, 3'd0));    // query, no task
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_STOP, 8'd0, 3'd0));     // stop while stopped
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'hFF, 3'd7));
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'h00, 3'd0));
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'hA5, 3'd0)); // FIFO among equals
    pending_reqs.push_back(mk_req(CMD_SPARE_LO, 8'h5A, 3'd5));         // unused code
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_START, 8'd0, 3'd0));
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_START, 8'd0, 3'd0));    // start while running
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_QUERY, 8'd0, 3'd0));
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_RETURN, 8'd0, 3'd0));   // ended
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'h11, 3'd6)); // preempt
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'h22, 3'd7)); // already pending
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_RETURN, 8'd0, 3'd0));   // stacked
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_STOP, 8'd0, 3'd0));     // stop preempts
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_RETURN, 8'd0, 3'd0));
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_START, 8'd0, 3'd0));    // stack top outranks pool head
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_CLEAR, 8'd0, 3'd0));
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_STOP, 8'd0, 3'd0));
    for (k = 0; k < 18; k++)                                           // pool full
      pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'(k), 3'(k)));
    pending_reqs.push_back(mk_req(CMD_SPARE_HI, 8'd0, 3'd0));

    // Stop and return rounds: after a start, repeatedly stop, return, clear, enqueue, start.
    pending_reqs.push_back(mk_req(ppd_pkg::CMD_START, 8'd0, 3'd0));
    for (k = 0; k < 10; k++) begin
      pending_reqs.push_back(mk_req(ppd_pkg::CMD_STOP, 8'd0, 3'd0));
      pending_reqs.push_back(mk_req(ppd_pkg::CMD_RETURN, 8'd0, 3'd0));
      pending_reqs.push_back(mk_req(ppd_pkg::CMD_CLEAR, 8'd0, 3'd0));
      pending_reqs.push_back(mk_req(ppd_pkg::CMD_ENQUEUE, 8'(k), 3'd7));
      pending_reqs.push_back(mk_req(ppd_pkg::CMD_START, 8'd0, 3'd0));
    end

    // Random part, first half.
    for (k = 0; k < 700; k++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() == 0);

    // Pause the source until every result is back.
    hold_src = 1'b1;
    wait (expected_res.size() == 0);
    hold_src = 1'b0;

    // Long sink hold while the source keeps offering.
    for (k = 0; k < 800; k++) pending_reqs.push_back(rand_req());
    hold_sink = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_sink = 1'b0;
    wait (pending_reqs.size() == 0);

    wait (expected_res.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
